### sv/ipv6ehc_pkg.sv
// ----------------------------------------------------------------------------
// ipv6ehc_pkg
// Shared types, protocol numbers and helpers for the extension-header
// chain patcher.
// ----------------------------------------------------------------------------
package ipv6ehc_pkg;

    localparam logic [7:0] PROTO_HOPOPTS  = 8'd0;
    localparam logic [7:0] PROTO_ROUTING  = 8'd43;
    localparam logic [7:0] PROTO_FRAGMENT = 8'd44;
    localparam logic [7:0] PROTO_AH       = 8'd51;
    localparam logic [7:0] PROTO_DSTOPTS  = 8'd60;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       replaced;
        logic       last;
    } result_t;

    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    function automatic logic is_ext(input logic [7:0] p);
        return p inside {PROTO_HOPOPTS, PROTO_ROUTING, PROTO_FRAGMENT,
                         PROTO_AH, PROTO_DSTOPTS};
    endfunction

    function automatic logic [11:0] header_size(input logic [7:0] proto,
                                                input logic [7:0] len);
        logic [11:0] len_w;
        len_w = {4'd0, len};
        if (proto == PROTO_AH) begin
            return (len_w + 12'd2) << 2;
        end
        if (proto == PROTO_FRAGMENT) begin
            return 12'd8;
        end
        return (len_w + 12'd1) << 3;
    endfunction

endpackage

### sv/ipv6ehc_front.sv
// ----------------------------------------------------------------------------
// ipv6ehc_front
// Walks the header chain one byte per item and produces a queue entry of
// one or two results for each item that releases bytes.
// ----------------------------------------------------------------------------
module ipv6ehc_front
    import ipv6ehc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [7:0]  start_proto,
    input  logic [7:0]  upper_proto,
    input  logic [15:0] buffer_length,
    output logic        push,
    output entry_t      push_entry
);

    logic [15:0] byte_offset_reg, byte_offset_next;
    logic [16:0] header_start_reg, header_start_next;
    logic [7:0]  current_proto_reg, current_proto_next;
    logic        chain_active_reg, chain_active_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_valid_reg, held_valid_next;
    logic [7:0]  patch_value_reg, patch_value_next;
    logic [15:0] total_length_reg, total_length_next;

    logic [15:0] off_e;
    logic [16:0] hs_e;
    logic [7:0]  cp_e;
    logic        ca_e;
    logic        hv_e;
    logic [7:0]  pv_e;
    logic [15:0] tl_e;
    logic [17:0] next_start;
    logic        walk_end;
    logic        pre_valid;
    result_t     pre_res;
    result_t     main0, main1;
    logic [1:0]  main_cnt;

    always_comb
    begin
        if (first_byte) begin
            off_e = 16'd0;
            hs_e  = 17'd0;
            cp_e  = start_proto;
            ca_e  = is_ext(start_proto);
            hv_e  = 1'b0;
            pv_e  = upper_proto;
            tl_e  = buffer_length;
        end else begin
            off_e = byte_offset_reg;
            hs_e  = header_start_reg;
            cp_e  = current_proto_reg;
            ca_e  = chain_active_reg;
            hv_e  = held_valid_reg;
            pv_e  = patch_value_reg;
            tl_e  = total_length_reg;
        end

        pre_valid = first_byte && held_valid_reg;
        pre_res   = '{data: held_byte_reg, replaced: 1'b1, last: 1'b0};

        next_start = {1'b0, hs_e} + {6'd0, header_size(cp_e, data_byte)};
        walk_end   = !is_ext(held_byte_reg) || (next_start >= {2'd0, tl_e});

        header_start_next  = hs_e;
        current_proto_next = cp_e;
        chain_active_next  = ca_e;
        held_byte_next     = held_byte_reg;
        held_valid_next    = hv_e;
        patch_value_next   = pv_e;
        total_length_next  = tl_e;

        main0    = '{data: data_byte, replaced: 1'b0, last: last_byte};
        main1    = '{data: data_byte, replaced: 1'b0, last: last_byte};
        main_cnt = 2'd1;

        if (ca_e && hv_e) begin
            if (walk_end) begin
                main0 = '{data: pv_e, replaced: 1'b1, last: 1'b0};
                chain_active_next = 1'b0;
            end else begin
                main0 = '{data: held_byte_reg, replaced: 1'b0, last: 1'b0};
                header_start_next  = next_start[16:0];
                current_proto_next = held_byte_reg;
            end
            held_valid_next = 1'b0;
            main_cnt = 2'd2;
        end else if (ca_e && ({1'b0, off_e} == hs_e)) begin
            if (cp_e == PROTO_FRAGMENT || last_byte) begin
                main0 = '{data: pv_e, replaced: 1'b1, last: last_byte};
                chain_active_next = 1'b0;
            end else begin
                held_byte_next  = data_byte;
                held_valid_next = 1'b1;
                main_cnt = 2'd0;
            end
        end

        byte_offset_next = off_e + 16'd1;
        if (last_byte) begin
            chain_active_next = 1'b0;
            held_valid_next   = 1'b0;
        end

        if (pre_valid) begin
            push_entry = '{two: main_cnt != 2'd0, r0: pre_res, r1: main0};
            push       = accept;
        end else begin
            push_entry = '{two: main_cnt == 2'd2, r0: main0, r1: main1};
            push       = accept && (main_cnt != 2'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_offset_reg   <= '0;
            header_start_reg  <= '0;
            current_proto_reg <= '0;
            chain_active_reg  <= 1'b0;
            held_byte_reg     <= '0;
            held_valid_reg    <= 1'b0;
            patch_value_reg   <= '0;
            total_length_reg  <= '0;
        end else if (accept) begin
            byte_offset_reg   <= byte_offset_next;
            header_start_reg  <= header_start_next;
            current_proto_reg <= current_proto_next;
            chain_active_reg  <= chain_active_next;
            held_byte_reg     <= held_byte_next;
            held_valid_reg    <= held_valid_next;
            patch_value_reg   <= patch_value_next;
            total_length_reg  <= total_length_next;
        end
    end

endmodule

### sv/ipv6ehc_queue.sv
// ----------------------------------------------------------------------------
// ipv6ehc_queue
// Small first-in first-out queue of result entries between the chain walk
// and the output stage.
// ----------------------------------------------------------------------------
module ipv6ehc_queue
    import ipv6ehc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   full,
    output logic   not_empty,
    output entry_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t        slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### sv/ipv6ehc_back.sv
// ----------------------------------------------------------------------------
// ipv6ehc_back
// Output stage: takes one entry from the queue and delivers its one or two
// results in order on the output channel.
// ----------------------------------------------------------------------------
module ipv6ehc_back
    import ipv6ehc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_not_empty,
    input  entry_t     q_head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       was_replaced,
    output logic       last_out
);

    entry_t  entry_reg;
    logic    busy_reg, busy_next;
    logic    sel_reg, sel_next;
    logic    slot_free;
    result_t cur;

    assign cur          = sel_reg ? entry_reg.r1 : entry_reg.r0;
    assign out_valid    = busy_reg;
    assign out_byte     = cur.data;
    assign was_replaced = cur.replaced;
    assign last_out     = cur.last;

    always_comb
    begin
        slot_free = !busy_reg || (out_ready && (sel_reg || !entry_reg.two));
        pop       = slot_free && q_not_empty;
        busy_next = busy_reg;
        sel_next  = sel_reg;
        if (slot_free) begin
            busy_next = q_not_empty;
            sel_next  = 1'b0;
        end else if (out_ready) begin
            sel_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            sel_reg  <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            sel_reg  <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            entry_reg <= q_head;
        end
    end

endmodule

### sv/ipv6_exthdr_chain_patcher.sv
// ----------------------------------------------------------------------------
// ipv6_exthdr_chain_patcher
// Passes an IPv6 extension-header buffer through byte by byte and replaces
// the next-header byte of the last header in the chain.
//
//   Channel   Handshake              Payload
//   input     in_valid / in_ready    data_byte, first_byte, last_byte,
//                                    start_proto, upper_proto, buffer_length
//   output    out_valid / out_ready  out_byte, was_replaced, last_out
//
// One input item is taken per cycle while the queue has room; the chain walk
// is one header-size add and one compare per byte.
// Output items leave at one per cycle from the output register while out_ready
// is high, so a released held byte and its length byte leave one after the other.
// A stalled output fills the queue of QUEUE_DEPTH entries before in_ready
// drops. Reset clears the walk state and the queue at once.
// ----------------------------------------------------------------------------
module ipv6_exthdr_chain_patcher
    import ipv6ehc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [7:0]  start_proto,
    input  logic [7:0]  upper_proto,
    input  logic [15:0] buffer_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        was_replaced,
    output logic        last_out
);

    logic   accept;
    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   q_full;
    logic   q_not_empty;
    entry_t q_head;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    ipv6ehc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .first_byte    (first_byte),
        .last_byte     (last_byte),
        .start_proto   (start_proto),
        .upper_proto   (upper_proto),
        .buffer_length (buffer_length),
        .push          (push),
        .push_entry    (push_entry)
    );

    ipv6ehc_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    ipv6ehc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .was_replaced (was_replaced),
        .last_out     (last_out)
    );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Streams extension-header buffers through the chain patcher and checks every
// output item against a byte-level model of the header walk. A short table of
// hand-picked items comes first, followed by random buffers: mostly
// well-formed header chains, plus truncated buffers, missing length bytes and
// stray bytes. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    import ipv6ehc_pkg::*;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam int RAND_ITEMS = 1400;
    localparam int DIR_N = 23;

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [7:0]  sproto;
        logic [7:0]  uproto;
        logic [15:0] blen;
    } byte_item_t;

    localparam int ITEM_W = $bits(byte_item_t);

    typedef struct packed {
        byte_item_t stim;
        logic       typed;
        result_t    res;
    } dir_row_t;

    localparam result_t NO_RES = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'd0;
    logic        first_byte = 1'b0;
    logic        last_byte = 1'b0;
    logic [7:0]  start_proto = 8'd0;
    logic [7:0]  upper_proto = 8'd0;
    logic [15:0] buffer_length = 16'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        was_replaced;
    logic        last_out;

    logic [15:0] walk_off = '0;
    logic [16:0] hdr_start = '0;
    logic [7:0]  walk_proto = '0;
    bit          walk_on = 1'b0;
    logic [7:0]  nh_byte = '0;
    bit          nh_held = 1'b0;
    logic [7:0]  patch_proto = '0;
    logic [15:0] buf_len = '0;

    result_t     step_q [$];
    result_t     out_due_q [$];
    byte_item_t  pend_q [$];
    int          bad_count = 0;
    bit          calm = 1'b0;

    dir_row_t dir_tab [0:DIR_N-1] = '{
        '{'{8'hA5, 1'b0, 1'b0, 8'h00, 8'h00, 16'h0000}, 1'b1, '{8'hA5, 1'b0, 1'b0}},
        '{'{8'hFF, 1'b0, 1'b1, 8'hFF, 8'hFF, 16'hFFFF}, 1'b1, '{8'hFF, 1'b0, 1'b1}},
        '{'{8'h00, 1'b1, 1'b0, PROTO_TCP, 8'h11, 16'd3}, 1'b1, '{8'h00, 1'b0, 1'b0}},
        '{'{8'h3C, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0}, 1'b1, '{8'h3C, 1'b0, 1'b0}},
        '{'{8'h2C, 1'b0, 1'b1, 8'h00, 8'h00, 16'd0}, 1'b1, '{8'h2C, 1'b0, 1'b1}},
        '{'{8'h06, 1'b1, 1'b0, PROTO_FRAGMENT, 8'hFF, 16'd8}, 1'b1, '{8'hFF, 1'b1, 1'b0}},
        '{'{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0}, 1'b0, NO_RES},
        '{'{8'hFF, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0}, 1'b0, NO_RES},
        '{'{8'h80, 1'b0, 1'b1, 8'h00, 8'h00, 16'd0}, 1'b0, NO_RES},
        '{'{PROTO_AH, 1'b1, 1'b0, PROTO_HOPOPTS, PROTO_UDP, 16'd20}, 1'b0, NO_RES},
        '{'{8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0}, 1'b0, NO_RES},
        '{'{8'h01, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0}, 1'b0, NO_RES},
        '{'{8'h02, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0}, 1'b0, NO_RES},
        '{'{8'h03, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0}, 1'b0, NO_RES},
        '{'{8'h04, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0}, 1'b0, NO_RES},
        '{'{8'h05, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0}, 1'b0, NO_RES},
        '{'{8'h06, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0}, 1'b0, NO_RES},
        '{'{PROTO_TCP, 1'b0, 1'b0, 8'h00, 8'h00, 16'd0}, 1'b0, NO_RES},
        '{'{8'h01, 1'b0, 1'b1, 8'h00, 8'h00, 16'd0}, 1'b0, NO_RES},
        '{'{8'h00, 1'b1, 1'b0, PROTO_DSTOPTS, 8'h22, 16'hFFFF}, 1'b0, NO_RES},
        '{'{8'h11, 1'b1, 1'b0, PROTO_ROUTING, 8'h33, 16'd1}, 1'b0, NO_RES},
        '{'{8'hFF, 1'b0, 1'b1, 8'h00, 8'h00, 16'd0}, 1'b0, NO_RES},
        '{'{8'h7F, 1'b1, 1'b1, PROTO_HOPOPTS, 8'h44, 16'd5}, 1'b1, '{8'h44, 1'b1, 1'b1}}
    };

    ipv6_exthdr_chain_patcher u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .first_byte    (first_byte),
        .last_byte     (last_byte),
        .start_proto   (start_proto),
        .upper_proto   (upper_proto),
        .buffer_length (buffer_length),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .was_replaced  (was_replaced),
        .last_out      (last_out)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[ipv6_exthdr_chain_patcher] ERROR");
        $finish;
    end

    function automatic bit ext_hdr(input logic [7:0] p);
        case (p)
            PROTO_HOPOPTS, PROTO_ROUTING, PROTO_FRAGMENT, PROTO_AH, PROTO_DSTOPTS:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic int unsigned hdr_span(input logic [7:0] proto,
                                             input logic [7:0] len);
        case (proto)
            PROTO_AH:       return 4 * ({24'd0, len} + 2);
            PROTO_FRAGMENT: return 8;
            default:        return 8 * ({24'd0, len} + 1);
        endcase
    endfunction

    function automatic result_t res(input logic [7:0] b, input logic r, input logic l);
        result_t x;
        x.data = b;
        x.replaced = r;
        x.last = l;
        return x;
    endfunction

    function automatic int pick_gap();
        return calm ? 0 : $urandom_range(0, 7);
    endfunction

    function automatic logic [7:0] pick_ext();
        case ($urandom_range(0, 4))
            0:       return PROTO_HOPOPTS;
            1:       return PROTO_ROUTING;
            2:       return PROTO_FRAGMENT;
            3:       return PROTO_AH;
            default: return PROTO_DSTOPTS;
        endcase
    endfunction

    function automatic logic [7:0] pick_end();
        logic [7:0] p;
        if ($urandom_range(0, 3) == 0)
        begin
            return pick_ext();
        end
        do
            p = 8'($urandom);
        while (ext_hdr(p));
        return p;
    endfunction

    // Advances the header walk by one input byte and queues the output items
    // it releases in step_q.
    task automatic walk_chain(input byte_item_t it);
        int unsigned nxt;
        if (it.first)
        begin
            if (nh_held)
            begin
                step_q.push_back(res(nh_byte, 1'b1, 1'b0));
            end
            nh_held = 1'b0;
            walk_off = '0;
            hdr_start = '0;
            walk_proto = it.sproto;
            patch_proto = it.uproto;
            buf_len = it.blen;
            walk_on = ext_hdr(it.sproto);
        end
        if (walk_on && nh_held)
        begin
            nxt = hdr_start + hdr_span(walk_proto, it.data);
            if (!ext_hdr(nh_byte) || nxt >= buf_len)
            begin
                step_q.push_back(res(patch_proto, 1'b1, 1'b0));
                walk_on = 1'b0;
            end
            else
            begin
                step_q.push_back(res(nh_byte, 1'b0, 1'b0));
                hdr_start = 17'(nxt);
                walk_proto = nh_byte;
            end
            nh_held = 1'b0;
            step_q.push_back(res(it.data, 1'b0, it.last));
        end
        else if (walk_on && {1'b0, walk_off} == hdr_start)
        begin
            if (walk_proto == PROTO_FRAGMENT)
            begin
                step_q.push_back(res(patch_proto, 1'b1, it.last));
                walk_on = 1'b0;
            end
            else if (it.last)
            begin
                step_q.push_back(res(patch_proto, 1'b1, 1'b1));
                walk_on = 1'b0;
            end
            else
            begin
                nh_byte = it.data;
                nh_held = 1'b1;
            end
        end
        else
        begin
            step_q.push_back(res(it.data, 1'b0, it.last));
        end
        walk_off = walk_off + 16'd1;
        if (it.last)
        begin
            walk_on = 1'b0;
            nh_held = 1'b0;
        end
    endtask

    // Builds one buffer of items in pend_q. A broken buffer may carry stray
    // bytes in front, a random length byte, a cut and no end mark.
    task automatic queue_buffer(input bit broken);
        logic [7:0]  bq [$];
        logic [7:0]  sproto;
        logic [7:0]  uproto;
        logic [7:0]  cur;
        logic [7:0]  nh;
        logic [7:0]  len;
        logic [15:0] blen;
        int          nhdr;
        int          span;
        int          k;
        int          j;
        bit          mark;
        byte_item_t  it;
        if (broken && $urandom_range(0, 2) == 0)
        begin
            for (k = $urandom_range(1, 4); k > 0; k--)
            begin
                it = byte_item_t'(ITEM_W'({$urandom, $urandom}));
                it.first = 1'b0;
                it.last = 1'b0;
                pend_q.push_back(it);
            end
        end
        sproto = ($urandom_range(0, 9) == 0) ? 8'($urandom) : pick_ext();
        uproto = 8'($urandom);
        cur = sproto;
        nhdr = $urandom_range(1, 4);
        if (ext_hdr(sproto))
        begin
            for (k = 0; k < nhdr && ext_hdr(cur); k++)
            begin
                nh = (k == nhdr - 1) ? pick_end() : pick_ext();
                len = 8'((cur == PROTO_AH) ? $urandom_range(0, 3) : $urandom_range(0, 2));
                if (broken && $urandom_range(0, 3) == 0)
                begin
                    len = 8'($urandom);
                end
                span = hdr_span(cur, len);
                bq.push_back(nh);
                bq.push_back(len);
                if (span > 40)
                begin
                    break;
                end
                for (j = 2; j < span; j++)
                begin
                    bq.push_back(8'($urandom));
                end
                cur = nh;
            end
            for (j = $urandom_range(0, 6); j > 0; j--)
            begin
                bq.push_back(8'($urandom));
            end
        end
        else
        begin
            for (j = $urandom_range(1, 10); j > 0; j--)
            begin
                bq.push_back(8'($urandom));
            end
        end
        case ($urandom_range(0, 9))
            6:       blen = 16'($urandom_range(1, bq.size()));
            7:       blen = 16'(bq.size() + $urandom_range(1, 40));
            8:       blen = 16'($urandom) | 16'h8000;
            9:       blen = 16'($urandom_range(1, 65535));
            default: blen = 16'(bq.size());
        endcase
        mark = 1'b1;
        if (broken)
        begin
            k = $urandom_range(1, bq.size());
            while (bq.size() > k)
            begin
                void'(bq.pop_back());
            end
            mark = 1'($urandom_range(0, 1));
        end
        for (j = 0; j < bq.size(); j++)
        begin
            it = byte_item_t'(ITEM_W'({$urandom, $urandom}));
            it.data = bq[j];
            it.first = (j == 0);
            it.last = mark && (j == bq.size() - 1);
            if (j == 0)
            begin
                it.sproto = sproto;
                it.uproto = uproto;
                it.blen = blen;
            end
            pend_q.push_back(it);
        end
    endtask

    task automatic push_item(input byte_item_t it, input bit typed, input result_t typed_res);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= it.data;
        first_byte <= it.first;
        last_byte <= it.last;
        start_proto <= it.sproto;
        upper_proto <= it.uproto;
        buffer_length <= it.blen;
        do
            @(posedge clk);
        while (!in_ready);
        walk_chain(it);
        if (typed)
        begin
            step_q.delete();
            out_due_q.push_back(typed_res);
        end
        while (step_q.size() != 0)
        begin
            out_due_q.push_back(step_q.pop_front());
        end
        @(negedge clk);
    endtask

    task automatic note_mismatch(input result_t want, input bit have_want);
        bad_count++;
        if (bad_count <= 10)
        begin
            if (have_want)
            begin
                $display("mismatch: expected byte %02h rep %0b last %0b,",
                         want.data, want.replaced, want.last,
                         " got byte %02h rep %0b last %0b",
                         out_byte, was_replaced, last_out);
            end
            else
            begin
                $display("unexpected output item: byte %02h rep %0b last %0b",
                         out_byte, was_replaced, last_out);
            end
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (out_due_q.size() == 0)
            begin
                note_mismatch(NO_RES, 1'b0);
            end
            else
            begin
                want = out_due_q.pop_front();
                if (out_byte !== want.data || was_replaced !== want.replaced ||
                    last_out !== want.last)
                begin
                    note_mismatch(want, 1'b1);
                end
            end
        end
    end

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        int  k;
        int  sent;
        int  guard;
        bit  paused;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (k = 0; k < DIR_N; k++)
        begin
            push_item(dir_tab[k].stim, dir_tab[k].typed, dir_tab[k].res);
        end
        sent = 0;
        paused = 1'b0;
        while (sent < RAND_ITEMS)
        begin
            calm = ($urandom_range(0, 7) == 0);
            queue_buffer($urandom_range(0, 3) == 0);
            while (pend_q.size() != 0)
            begin
                push_item(pend_q.pop_front(), 1'b0, NO_RES);
                sent++;
            end
            if (!paused && sent >= RAND_ITEMS / 2)
            begin
                paused = 1'b1;
                in_valid <= 1'b0;
                do
                    @(negedge clk);
                while (out_due_q.size() != 0);
            end
        end
        queue_buffer(1'b0);
        while (pend_q.size() != 0)
        begin
            push_item(pend_q.pop_front(), 1'b0, NO_RES);
        end
        in_valid <= 1'b0;
        guard = 0;
        while (out_due_q.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);
        bad_count += out_due_q.size();
        if (bad_count == 0)
        begin
            $display("[ipv6_exthdr_chain_patcher] OK");
        end
        else
        begin
            $display("[ipv6_exthdr_chain_patcher] ERROR");
        end
        $finish;
    end

endmodule
